/* rtl/cialu_pkg.sv */
// ----------------------------------------------------------------------------
// cialu_pkg - shared types and helpers for the checked integer ALU
// Request/response payloads, operation and width codes, width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cialu_pkg;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_CVT = 2'd3
   } action_type;

   localparam logic [1:0] WC_8  = 2'd0;
   localparam logic [1:0] WC_16 = 2'd1;
   localparam logic [1:0] WC_32 = 2'd2;
   localparam logic [1:0] WC_64 = 2'd3;

   typedef struct packed {
      action_type  action;
      logic [1:0]  width_code;
      logic        source_signed;
      logic        result_signed;
      logic [63:0] lhs;
      logic [63:0] rhs;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        overflow;
   } rsp_type;

   // control that rides along with each request through the stages
   typedef struct packed {
      action_type  op;
      logic [1:0]  wc;
      logic        ssg;
      logic        neg;
   } ctl_type;

   // unsigned maximum of the result width
   function automatic logic [63:0] umax_w(input logic [1:0] wc);
      logic [63:0] m;
      unique case (wc)
         WC_8:  m = 64'h0000_0000_0000_00FF;
         WC_16: m = 64'h0000_0000_0000_FFFF;
         WC_32: m = 64'h0000_0000_FFFF_FFFF;
         WC_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // sign bit of the result width, also the magnitude of the signed minimum
   function automatic logic [63:0] sbit_w(input logic [1:0] wc);
      logic [63:0] m;
      unique case (wc)
         WC_8:  m = 64'h0000_0000_0000_0080;
         WC_16: m = 64'h0000_0000_0000_8000;
         WC_32: m = 64'h0000_0000_8000_0000;
         WC_64: m = 64'h8000_0000_0000_0000;
      endcase
      return m;
   endfunction

   // take the low bits of the width and sign- or zero-extend them to 64
   function automatic logic [63:0] ext_w(input logic [63:0] v, input logic [1:0] wc,
                                         input logic sgn);
      logic [63:0] r;
      unique case (wc)
         WC_8:  r = {{56{sgn & v[7]}}, v[7:0]};
         WC_16: r = {{48{sgn & v[15]}}, v[15:0]};
         WC_32: r = {{32{sgn & v[31]}}, v[31:0]};
         WC_64: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/checked_integer_alu.sv */
// ----------------------------------------------------------------------------
// checked_integer_alu - overflow-checked add, subtract, multiply and convert
// Four-stage pipeline; result is zero whenever the overflow flag is set.
// ----------------------------------------------------------------------------
// A request passes the stage 1, 2, 3 and output registers before rsp_valid.
// Throughput: one request per cycle while the output does not stall; the 64x64 multiply is split into four
//   32x32 partial products in stage 2 and summed in stage 3.
// Each stage has its own valid bit, so bubbles fill while the output stalls.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module checked_integer_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire cialu_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      cialu_pkg::rsp_type rsp_data
);

   // ------------------------------------------------------------------------
   // stage flow control: a stage takes new data when empty or draining
   // ------------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic out_ready, s3_ready, s2_ready, s1_ready;

   assign out_ready = !out_v_ff || !rsp_stall;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_v_ff  <= req_valid;
         if (s2_ready)  s2_v_ff  <= s1_v_ff;
         if (s3_ready)  s3_v_ff  <= s2_v_ff;
         if (out_ready) out_v_ff <= s3_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: operand extension, multiply magnitudes, convert range check
   // ------------------------------------------------------------------------
   cialu_pkg::ctl_type s1_ctl_in, s1_ctl_ff;
   logic [63:0] lhs_x, rhs_x;
   logic        lhs_neg, rhs_neg;
   logic [63:0] s1_a_in, s1_a_ff, s1_b_ff;
   logic [63:0] s1_ma_in, s1_ma_ff, s1_mb_in, s1_mb_ff;
   logic [63:0] in_umax, in_smax;
   logic        s1_cvt_in, s1_cvt_ff;

   always_comb begin
      lhs_x   = cialu_pkg::ext_w(req_data.lhs, req_data.width_code, req_data.source_signed);
      rhs_x   = cialu_pkg::ext_w(req_data.rhs, req_data.width_code, req_data.source_signed);
      lhs_neg = req_data.source_signed & lhs_x[63];
      rhs_neg = req_data.source_signed & rhs_x[63];
      // magnitudes feed the unsigned multiplier; unsigned operands pass as-is
      s1_ma_in = lhs_neg ? (64'd0 - lhs_x) : lhs_x;
      s1_mb_in = rhs_neg ? (64'd0 - rhs_x) : rhs_x;
      // convert carries the full 64-bit source through untouched
      s1_a_in  = (req_data.action == cialu_pkg::ACT_CVT) ? req_data.lhs : lhs_x;

      in_umax = cialu_pkg::umax_w(req_data.width_code);
      in_smax = in_umax >> 1;
      case ({req_data.source_signed, req_data.result_signed})
         2'b11:   s1_cvt_in = cialu_pkg::ext_w(req_data.lhs, req_data.width_code, 1'b1)
                              != req_data.lhs;
         2'b10:   s1_cvt_in = req_data.lhs[63] | (|(req_data.lhs & ~in_umax));
         2'b01:   s1_cvt_in = |(req_data.lhs & ~in_smax);
         default: s1_cvt_in = |(req_data.lhs & ~in_umax);
      endcase

      s1_ctl_in.op  = req_data.action;
      s1_ctl_in.wc  = req_data.width_code;
      s1_ctl_in.ssg = req_data.source_signed;
      s1_ctl_in.neg = lhs_neg ^ rhs_neg;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ctl_ff <= s1_ctl_in;
         s1_a_ff   <= s1_a_in;
         s1_b_ff   <= rhs_x;
         s1_ma_ff  <= s1_ma_in;
         s1_mb_ff  <= s1_mb_in;
         s1_cvt_ff <= s1_cvt_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: partial products, add/subtract with 64-bit overflow
   // ------------------------------------------------------------------------
   cialu_pkg::ctl_type s2_ctl_ff;
   logic [63:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [63:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic        is_sub;
   logic [63:0] b_op, sum;
   logic [64:0] sum_wide;
   logic        v64;
   logic [63:0] s2_val_in, s2_val_ff;
   logic        s2_flag_in, s2_flag_ff;

   always_comb begin
      pp_ll_in = {32'd0, s1_ma_ff[31:0]}  * {32'd0, s1_mb_ff[31:0]};
      pp_lh_in = {32'd0, s1_ma_ff[31:0]}  * {32'd0, s1_mb_ff[63:32]};
      pp_hl_in = {32'd0, s1_ma_ff[63:32]} * {32'd0, s1_mb_ff[31:0]};
      pp_hh_in = {32'd0, s1_ma_ff[63:32]} * {32'd0, s1_mb_ff[63:32]};

      is_sub   = (s1_ctl_ff.op == cialu_pkg::ACT_SUB);
      b_op     = is_sub ? ~s1_b_ff : s1_b_ff;
      sum_wide = {1'b0, s1_a_ff} + {1'b0, b_op} + {64'd0, is_sub};
      sum      = sum_wide[63:0];
      if (is_sub)
         v64 = (s1_a_ff[63] ^ s1_b_ff[63]) & (s1_a_ff[63] ^ sum[63]);
      else
         v64 = (s1_a_ff[63] ^ sum[63]) & (s1_b_ff[63] ^ sum[63]);

      // flag: 64-bit overflow of add/sub, or the convert range result
      case (s1_ctl_ff.op)
         cialu_pkg::ACT_CVT: s2_flag_in = s1_cvt_ff;
         cialu_pkg::ACT_ADD: s2_flag_in = s1_ctl_ff.ssg ? v64 : sum_wide[64];
         cialu_pkg::ACT_SUB: s2_flag_in = s1_ctl_ff.ssg ? v64 : !sum_wide[64];
         default:            s2_flag_in = 1'b0;
      endcase
      s2_val_in = (s1_ctl_ff.op == cialu_pkg::ACT_CVT) ? s1_a_ff : sum;
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ctl_ff  <= s1_ctl_ff;
         pp_ll_ff   <= pp_ll_in;
         pp_lh_ff   <= pp_lh_in;
         pp_hl_ff   <= pp_hl_in;
         pp_hh_ff   <= pp_hh_in;
         s2_val_ff  <= s2_val_in;
         s2_flag_ff <= s2_flag_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: product assembly, width fit check for add/subtract
   // ------------------------------------------------------------------------
   cialu_pkg::ctl_type s3_ctl_ff;
   logic [33:0] mid;
   logic [63:0] prod_lo, prod_hi;
   logic [63:0] s2_umax;
   logic        fit_bad;
   logic [63:0] s3_val_in, s3_val_ff;
   logic        s3_ovf_in, s3_ovf_ff;

   always_comb begin
      mid     = {2'b00, pp_ll_ff[63:32]} + {2'b00, pp_lh_ff[31:0]} + {2'b00, pp_hl_ff[31:0]};
      prod_lo = {mid[31:0], pp_ll_ff[31:0]};
      prod_hi = pp_hh_ff + {32'd0, pp_lh_ff[63:32]} + {32'd0, pp_hl_ff[63:32]}
                + {62'd0, mid[33:32]};

      s2_umax = cialu_pkg::umax_w(s2_ctl_ff.wc);
      if (s2_ctl_ff.ssg)
         fit_bad = cialu_pkg::ext_w(s2_val_ff, s2_ctl_ff.wc, 1'b1) != s2_val_ff;
      else
         fit_bad = |(s2_val_ff & ~s2_umax);

      case (s2_ctl_ff.op)
         cialu_pkg::ACT_MUL: begin
            s3_ovf_in = |prod_hi;
            s3_val_in = prod_lo;
         end
         cialu_pkg::ACT_CVT: begin
            s3_ovf_in = s2_flag_ff;
            s3_val_in = s2_val_ff;
         end
         default: begin
            s3_ovf_in = s2_flag_ff | fit_bad;
            s3_val_in = s2_val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_val_ff <= s3_val_in;
         s3_ovf_ff <= s3_ovf_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: product range check, sign restore, zero on overflow
   // ------------------------------------------------------------------------
   logic [63:0] s3_umax, s3_smax;
   logic        mul_over;
   logic [63:0] fin_val;
   logic        fin_ovf;
   cialu_pkg::rsp_type out_in, out_ff;

   always_comb begin
      s3_umax = cialu_pkg::umax_w(s3_ctl_ff.wc);
      s3_smax = s3_umax >> 1;
      fin_val = s3_val_ff;
      if (s3_ctl_ff.ssg) begin
         // a negative product may reach the signed minimum exactly
         mul_over = (|(s3_val_ff & ~s3_smax))
                    && !(s3_ctl_ff.neg && (s3_val_ff == cialu_pkg::sbit_w(s3_ctl_ff.wc)));
      end else begin
         mul_over = |(s3_val_ff & ~s3_umax);
      end
      if (s3_ctl_ff.op == cialu_pkg::ACT_MUL) begin
         fin_ovf = s3_ovf_ff | mul_over;
         if (s3_ctl_ff.neg) fin_val = 64'd0 - s3_val_ff;
      end else begin
         fin_ovf = s3_ovf_ff;
      end
      out_in.overflow = fin_ovf;
      out_in.result   = fin_ovf ? 64'd0 : fin_val;
   end

   always_ff @(posedge clock) begin
      if (out_ready) out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   // a flagged response never carries a value
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.overflow) |-> (out_ff.result == 64'd0))
      else $error("overflow response with nonzero result");

   // input is held off only when every stage is occupied and the output stalls
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff && rsp_stall))
      else $error("request stalled with a free pipeline slot");

   // an accepted request lands in stage 1
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_v_ff)
      else $error("accepted request lost at stage 1");

   // a blocked stage-3 entry is not dropped
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !out_ready) |=> (s3_v_ff && $stable(s3_val_ff)))
      else $error("stage 3 entry changed while blocked");
`endif

endmodule

`default_nettype wire

/* sim/checked_integer_alu_tb.sv */
// ----------------------------------------------------------------------------
// checked_integer_alu_tb - self-checking bench for the checked integer ALU
// Drives directed corner requests and then random ones through the
// valid/stall request channel, while the response side stalls at random.
// Each accepted request is predicted independently and the expected
// responses are compared in order, field by field, against what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_alu_tb;

   localparam int RANDOM_REQUESTS = 1100;
   localparam int DRAIN_POINT     = 550;   // sender holds off here until drained
   localparam int MAX_IDLE        = 5;     // longest gap / stall drawn per item
   localparam int PIPE_SLACK      = 12;    // margin over the pipeline latency
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all

   // -------------------------------------------------------------------------
   // Expected-response store and predictor. Every accepted request is turned
   // into the response the block must produce; responses leave in order.
   // -------------------------------------------------------------------------
   class checked_result_book;
      cialu_pkg::rsp_type expected_results[$];
      int                 mismatches;

      function new();
         mismatches = 0;
      endfunction

      // all-ones in the low W bits
      function logic [63:0] width_mask(logic [1:0] wc);
         case (wc)
            cialu_pkg::WC_8:  return 64'h0000_0000_0000_00FF;
            cialu_pkg::WC_16: return 64'h0000_0000_0000_FFFF;
            cialu_pkg::WC_32: return 64'h0000_0000_FFFF_FFFF;
            default:          return 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
      endfunction

      // low W bits of v, sign- or zero-filled up to 64
      function logic [63:0] widen(logic [63:0] v, logic [1:0] wc, bit sgn);
         logic [63:0] low;
         logic        top;
         low = v & width_mask(wc);
         case (wc)
            cialu_pkg::WC_8:  top = v[7];
            cialu_pkg::WC_16: top = v[15];
            cialu_pkg::WC_32: top = v[31];
            default:          top = v[63];
         endcase
         if (sgn && top)
            return low | ~width_mask(wc);
         return low;
      endfunction

      function bit fits_signed(logic [63:0] v, logic [1:0] wc);
         return widen(v, wc, 1'b1) == v;
      endfunction

      function cialu_pkg::rsp_type predict_checked(cialu_pkg::req_type q);
         cialu_pkg::rsp_type p;
         logic [63:0]        umax, smax, a, b, r, ma, mb, lo;
         logic [127:0]       prod;
         bit                 ovf, a_neg, b_neg;
         umax = width_mask(q.width_code);
         smax = umax >> 1;
         r    = '0;
         ovf  = 1'b0;
         if (q.action == cialu_pkg::ACT_CVT) begin
            // full 64-bit lhs is the source value; rhs plays no part
            r = q.lhs;
            if (q.source_signed && q.result_signed)
               ovf = !fits_signed(r, q.width_code);
            else if (q.source_signed)
               ovf = r[63] || (r > umax);
            else if (q.result_signed)
               ovf = r > smax;
            else
               ovf = r > umax;
         end else begin
            // arithmetic works on the low W bits; signedness from source only
            a = widen(q.lhs, q.width_code, q.source_signed);
            b = widen(q.rhs, q.width_code, q.source_signed);
            case (q.action)
               cialu_pkg::ACT_ADD: begin
                  r = a + b;
                  if (q.source_signed)
                     ovf = ((a ^ r) & (b ^ r)) >> 63 != 0 || !fits_signed(r, q.width_code);
                  else
                     ovf = (r < a) || (r > umax);
               end
               cialu_pkg::ACT_SUB: begin
                  r = a - b;
                  if (q.source_signed)
                     ovf = ((a ^ b) & (a ^ r)) >> 63 != 0 || !fits_signed(r, q.width_code);
                  else
                     ovf = b > a;
               end
               default: begin
                  if (q.source_signed) begin
                     // multiply magnitudes, then apply the sign
                     a_neg = a[63];
                     b_neg = b[63];
                     ma    = a_neg ? -a : a;
                     mb    = b_neg ? -b : b;
                     prod  = {64'd0, ma} * {64'd0, mb};
                     lo    = prod[63:0];
                     if (prod[127:64] != 0) begin
                        ovf = 1'b1;
                     end else if (a_neg != b_neg) begin
                        ovf = lo > smax + 64'd1;
                        r   = -lo;
                     end else begin
                        ovf = lo > smax;
                        r   = lo;
                     end
                  end else begin
                     prod = {64'd0, a} * {64'd0, b};
                     r    = prod[63:0];
                     ovf  = (prod[127:64] != 0) || (r > umax);
                  end
               end
            endcase
         end
         p.result   = ovf ? 64'd0 : r;
         p.overflow = ovf;
         return p;
      endfunction

      function void note_request(cialu_pkg::req_type q);
         expected_results.push_back(predict_checked(q));
      endfunction

      function void check_response(cialu_pkg::rsp_type got);
         cialu_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            $error("response with nothing outstanding: result %h overflow %b",
                   got.result, got.overflow);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got.result !== want.result) begin
            $error("result mismatch: expected %h, actual %h", want.result, got.result);
            mismatches++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %b, actual %b", want.overflow, got.overflow);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   cialu_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   cialu_pkg::rsp_type rsp_data;

   bit      no_idle   = 1'b0;   // set for stretches of back-to-back traffic
   int      idle_cycles = 0;

   checked_result_book book = new();

   initial begin
      forever #5 clock = ~clock;
   end

   checked_integer_alu uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Request side. Called at a clock edge; returns at the edge where the
   // request is taken, so the next call may keep valid high with no gap.
   // -------------------------------------------------------------------------
   task automatic send_request(input cialu_pkg::req_type q);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall !== 1'b0);
      book.note_request(q);
   endtask

   function automatic cialu_pkg::req_type make_req(cialu_pkg::action_type act,
                                                   logic [1:0] wc, bit ss, bit rs,
                                                   logic [63:0] lhs, logic [63:0] rhs);
      cialu_pkg::req_type q;
      q.action        = act;
      q.width_code    = wc;
      q.source_signed = ss;
      q.result_signed = rs;
      q.lhs           = lhs;
      q.rhs           = rhs;
      return q;
   endfunction

   // boundary values around each width, both sign-extended and not
   function automatic logic [63:0] corner_value();
      case ($urandom_range(0, 15))
         0:  return 64'h0000_0000_0000_0000;
         1:  return 64'h0000_0000_0000_0001;
         2:  return 64'hFFFF_FFFF_FFFF_FFFF;
         3:  return 64'h0000_0000_0000_007F;
         4:  return 64'h0000_0000_0000_0080;
         5:  return 64'hFFFF_FFFF_FFFF_FF80;
         6:  return 64'h0000_0000_0000_00FF;
         7:  return 64'h0000_0000_0000_7FFF;
         8:  return 64'hFFFF_FFFF_FFFF_8000;
         9:  return 64'h0000_0000_0000_FFFF;
         10: return 64'h0000_0000_7FFF_FFFF;
         11: return 64'hFFFF_FFFF_8000_0000;
         12: return 64'h0000_0000_FFFF_FFFF;
         13: return 64'h7FFF_FFFF_FFFF_FFFF;
         14: return 64'h8000_0000_0000_0000;
         default: return 64'h0000_0001_0000_0000;
      endcase
   endfunction

   // mix of raw random, corners, near-corners and small magnitudes (the
   // latter keep multiplies from overflowing every time)
   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      int          nb;
      case ($urandom_range(0, 9)) inside
         [0:2]: v = {$urandom, $urandom};
         [3:4]: v = corner_value();
         [5:7]: begin
            nb = $urandom_range(1, 40);
            v  = {$urandom, $urandom} & ((64'd1 << nb) - 64'd1);
            if ($urandom_range(0, 1) != 0)
               v = -v;
         end
         default: v = corner_value() + 64'($urandom_range(0, 6)) - 64'd3;
      endcase
      return v;
   endfunction

   function automatic cialu_pkg::req_type random_req();
      cialu_pkg::req_type q;
      q.action        = cialu_pkg::action_type'($urandom_range(0, 3));
      q.width_code    = 2'($urandom_range(0, 3));
      q.source_signed = 1'($urandom_range(0, 1));
      // result signedness tracks the source for arithmetic, mostly
      if (q.action == cialu_pkg::ACT_CVT || $urandom_range(0, 9) == 0)
         q.result_signed = 1'($urandom_range(0, 1));
      else
         q.result_signed = q.source_signed;
      q.lhs = pick_operand();
      q.rhs = pick_operand();
      return q;
   endfunction

   // -------------------------------------------------------------------------
   // Response side: stalls for a random stretch before taking each
   // response, then checks it against the oldest expectation.
   // -------------------------------------------------------------------------
   initial begin
      int hold;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         book.check_response(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long with no handshake on either channel means a hang.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: edges of each operation, width and signedness ---
      // unsigned add carry out at 8 and 64 bits
      send_request(make_req(cialu_pkg::ACT_ADD, cialu_pkg::WC_8, 1'b0, 1'b0,
                            64'hFF, 64'h01));
      send_request(make_req(cialu_pkg::ACT_ADD, cialu_pkg::WC_64, 1'b0, 1'b0,
                            '1, '1));
      // signed add past max, and min plus minus one at 64
      send_request(make_req(cialu_pkg::ACT_ADD, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'h7F, 64'h01));
      send_request(make_req(cialu_pkg::ACT_ADD, cialu_pkg::WC_64, 1'b1, 1'b1,
                            64'h8000_0000_0000_0000, '1));
      // high garbage above the width is dropped; result_signed ignored
      send_request(make_req(cialu_pkg::ACT_ADD, cialu_pkg::WC_16, 1'b1, 1'b0,
                            64'hDEAD_BEEF_CAFE_7FFE, 64'h1234_5678_9ABC_0001));
      // unsigned subtract with rhs above lhs; exact zero
      send_request(make_req(cialu_pkg::ACT_SUB, cialu_pkg::WC_16, 1'b0, 1'b0,
                            64'h0, 64'h1));
      send_request(make_req(cialu_pkg::ACT_SUB, cialu_pkg::WC_32, 1'b0, 1'b1,
                            64'hFFFF_FFFF, 64'hFFFF_FFFF));
      // signed subtract really subtracts: below min, zero minus min, and a small negative result
      send_request(make_req(cialu_pkg::ACT_SUB, cialu_pkg::WC_32, 1'b1, 1'b1,
                            64'h8000_0000, 64'h1));
      send_request(make_req(cialu_pkg::ACT_SUB, cialu_pkg::WC_64, 1'b1, 1'b1,
                            64'h0, 64'h8000_0000_0000_0000));
      send_request(make_req(cialu_pkg::ACT_SUB, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'h05, 64'h07));
      // unsigned multiply: upper product half nonzero, width overflow, and a full 64-bit result that fits
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_64, 1'b0, 1'b0,
                            64'h1_0000_0000, 64'h1_0000_0000));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_32, 1'b0, 1'b0,
                            64'hFFFF_FFFF, 64'hFFFF_FFFF));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_64, 1'b0, 1'b0,
                            64'hFFFF_FFFF, 64'h1_0000_0001));
      // signed multiply: minimum reached exactly, and its negation
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'h80, 64'h01));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'h80, 64'hFF));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_16, 1'b1, 1'b1,
                            64'hFF00, 64'h0080));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_64, 1'b1, 1'b1,
                            64'h8000_0000_0000_0000, '1));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_64, 1'b1, 1'b1,
                            64'h1_0000_0000, 64'h8000_0000));
      send_request(make_req(cialu_pkg::ACT_MUL, cialu_pkg::WC_64, 1'b1, 1'b1,
                            64'h1_0000_0000, 64'hFFFF_FFFF_8000_0000));
      // convert: signed to signed, signed to unsigned, unsigned to signed, unsigned to unsigned
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'hFFFF_FFFF_FFFF_FF80, '1));
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_8, 1'b1, 1'b1,
                            64'h80, 64'h0));
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_16, 1'b1, 1'b0,
                            '1, 64'h0));
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_16, 1'b1, 1'b0,
                            64'hFFFF, '1));
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_32, 1'b0, 1'b1,
                            64'h8000_0000, 64'h0));
      send_request(make_req(cialu_pkg::ACT_CVT, cialu_pkg::WC_64, 1'b0, 1'b0,
                            '1, '1));

      // --- random requests ---
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // back-to-back stretches on both sides
         no_idle = (i >= 200 && i < 320) || (i >= 850 && i < 900);
         if (i == DRAIN_POINT) begin
            // sender holds off until the pipeline has fully emptied
            req_valid <= 1'b0;
            while (book.outstanding() != 0) @(posedge clock);
         end
         send_request(random_req());
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow for any stray late response
      while (book.outstanding() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);

      if (book.mismatches == 0 && book.outstanding() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
